/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

/* hw/rtl/cbe_pkg.sv */
// Package with constants and types for the cubic Bezier easing block.
package cbe_pkg;
    localparam int FracBits = 16;
    localparam int MaxIterations = 24;
    localparam int QBits = 30;
    localparam int VW = 36;
    localparam int IterW = $clog2(MaxIterations + 1);

    typedef logic signed [VW-1:0] val_t;

    localparam val_t QOne = val_t'(64'sd1 << QBits);
    localparam val_t Tol = val_t'(64'sd1 << 10);

    localparam logic [1:0] ModeLinear = 2'd0;
    localparam logic [1:0] ModeExit = 2'd1;

    typedef struct packed {
        logic start;
        logic neg;
        val_t a;
        val_t b;
    } mul_req_t;

    typedef struct packed {
        logic start;
        val_t num;
        val_t den;
    } div_req_t;

    function automatic val_t ctrl_x1(input logic [1:0] m);
        return (m == ModeExit) ? QOne : '0;
    endfunction

    function automatic val_t ctrl_x2(input logic [1:0] m);
        return (m == ModeLinear || m == ModeExit) ? QOne : '0;
    endfunction

    function automatic val_t ctrl_y1(input logic [1:0] m);
        return '0;
    endfunction

    function automatic val_t ctrl_y2(input logic [1:0] m);
        return (m == ModeExit) ? QOne : ((m == ModeLinear) ? QOne : QOne);
    endfunction
endpackage

/* hw/rtl/cbe_mul.sv */
// Shared Q6.30 multiplier with rounding of magnitudes, one product at a time.
`include "assert_macros.svh"
module cbe_mul
    import cbe_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output logic     done,
    output val_t     prod
);
    logic [VW-1:0] ua_reg, ub_reg;
    logic neg_reg, busy_reg, done_reg;
    logic [2*VW-1:0] full;
    logic [2*VW-1:0] rnd;
    val_t prod_reg;

    assign full = {{VW{1'b0}}, ua_reg} * {{VW{1'b0}}, ub_reg};
    assign rnd = (full + ((2*VW)'(1) << (QBits - 1))) >> QBits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg;
            busy_reg <= req.start;
        end
        if (req.start) begin
            ua_reg <= req.a[VW-1] ? VW'(-req.a) : req.a;
            ub_reg <= req.b[VW-1] ? VW'(-req.b) : req.b;
            neg_reg <= req.neg ^ req.a[VW-1] ^ req.b[VW-1];
        end
        if (busy_reg) begin
            prod_reg <= neg_reg ? -val_t'(rnd[VW-1:0]) : val_t'(rnd[VW-1:0]);
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

    `ASSERT_NEVER(a_mul_overlap, aclk, aresetn, busy_reg && done_reg)
    `ASSERT_IMPL(a_mul_done, aclk, aresetn, busy_reg |=> done_reg)
    `ASSERT_IMPL(a_mul_start, aclk, aresetn, req.start |=> busy_reg)
endmodule

/* hw/rtl/cbe_div.sv */
// Restoring signed divider truncating toward zero with a saturated quotient, one bit per cycle.
`include "assert_macros.svh"
module cbe_div
    import cbe_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output logic     done,
    output val_t     quot
);
    localparam int NW = 2*VW;
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] num_reg, q_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic neg_reg, busy_reg, done_reg;
    logic [NW-1:0] rem_sh;
    logic signed [NW-1:0] wnum;
    logic [VW-1:0] qmag;

    assign wnum = NW'(req.num) <<< QBits;
    assign rem_sh = {rem_reg[NW-2:0], num_reg[NW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (req.start) begin
            num_reg <= wnum[NW-1] ? -wnum : wnum;
            den_reg <= NW'(req.den);
            neg_reg <= wnum[NW-1];
            rem_reg <= '0;
            q_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_reg << 1;
            if (rem_sh >= den_reg) begin
                rem_reg <= rem_sh - den_reg;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    // A quotient whose magnitude reaches 2^(VW-2) saturates to that value; the step is then outside the bracket.
    assign qmag = (q_reg[NW-1:VW-2] != '0) ? (VW'(1) << (VW - 2)) : q_reg[VW-1:0];
    assign done = done_reg;
    assign quot = neg_reg ? -val_t'(qmag) : val_t'(qmag);

    `ASSERT_NEVER(a_div_both, aclk, aresetn, busy_reg && done_reg)
    `ASSERT_IMPL(a_div_start, aclk, aresetn, req.start |=> busy_reg)
    `ASSERT_NEVER(a_div_idle_cnt, aclk, aresetn, busy_reg && cnt_reg == '0)
endmodule

/* hw/rtl/cubic_bezier_easing.sv */
// Top level of the cubic Bezier easing block: sequencer around a shared multiplier and divider.
//   channel  ports                          direction
//   s_       s_valid s_ready s_mode s_progress  in
//   m_       m_valid m_ready m_eased            out
// Zero progress, or progress of full scale or more, goes from S_IDLE straight to S_OUT,
// which then raises m_valid. Otherwise each Newton iteration runs on the shared multiplier
// and sequencer and, when the slope is positive, on the bit-serial divider, so the time until
// m_valid rises is set by the iteration count and the divider.
// Reset is synchronous and active low; s_ready is low from acceptance until the result
// leaves, and the result register holds while m_ready is low.
`include "assert_macros.svh"
module cubic_bezier_easing
    import cbe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [16:0] s_progress,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_eased
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_WAIT, S_EVAL, S_CHK, S_DIV, S_DWAIT, S_STEP, S_OUT, S_FIN
    } state_t;

    state_t state_reg;
    logic [1:0] mode_reg;
    logic yphase_reg;
    logic [IterW-1:0] iter_reg;
    logic [3:0] op_reg;
    val_t tgt_reg, t_reg, lo_reg, up_reg, err_reg;
    val_t t2_reg, m2_reg, mt_reg, acc_reg, dacc_reg, tmp_reg;
    logic [16:0] eased_reg;
    logic m_valid_reg;
    mul_req_t mreq;
    div_req_t dreq;
    logic mdone, ddone;
    val_t mprod, dquot, ca, cb, cand, mid;
    logic [VW-1:0] yr;

    assign ca = yphase_reg ? ctrl_y1(mode_reg) : ctrl_x1(mode_reg);
    assign cb = yphase_reg ? ctrl_y2(mode_reg) : ctrl_x2(mode_reg);
    assign cand = t_reg - dquot;
    assign mid = (lo_reg + up_reg) >>> 1;
    assign yr = VW'(acc_reg + val_t'(64'sd1 << (QBits - FracBits - 1))) >> (QBits - FracBits);

    cbe_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .done(mdone), .prod(mprod));
    cbe_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone), .quot(dquot));

    // Sequence of products: t2, m2, m2*t, *a, mt*t2, *b, t2*t, then slope terms.
    always_comb begin
        mreq = '0;
        if (state_reg == S_MUL) begin
            mreq.start = 1'b1;
            unique case (op_reg)
                4'd0: begin mreq.a = t_reg; mreq.b = t_reg; end
                4'd1: begin mreq.a = mt_reg; mreq.b = mt_reg; end
                4'd2: begin mreq.a = m2_reg; mreq.b = t_reg; end
                4'd3: begin mreq.a = tmp_reg; mreq.b = ca; end
                4'd4: begin mreq.a = mt_reg; mreq.b = t2_reg; end
                4'd5: begin mreq.a = tmp_reg; mreq.b = cb; end
                4'd6: begin mreq.a = t2_reg; mreq.b = t_reg; end
                4'd7: begin mreq.a = m2_reg; mreq.b = ca; end
                4'd8: begin mreq.a = mt_reg; mreq.b = t_reg; end
                4'd9: begin mreq.a = tmp_reg; mreq.b = cb - ca; end
                4'd10: begin mreq.a = t2_reg; mreq.b = QOne - cb; end
                default: begin mreq.a = '0; mreq.b = '0; end
            endcase
        end
        dreq.start = (state_reg == S_DIV);
        dreq.num = err_reg;
        dreq.den = dacc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg <= s_mode;
                        if (s_progress == '0) begin
                            eased_reg <= '0;
                            state_reg <= S_OUT;
                        end else if (s_progress >= 17'(1 << FracBits)) begin
                            eased_reg <= 17'(1 << FracBits);
                            state_reg <= S_OUT;
                        end else begin
                            tgt_reg <= val_t'(s_progress) <<< (QBits - FracBits);
                            t_reg <= val_t'(s_progress) <<< (QBits - FracBits);
                            mt_reg <= QOne - (val_t'(s_progress) <<< (QBits - FracBits));
                            lo_reg <= '0;
                            up_reg <= QOne;
                            iter_reg <= '0;
                            yphase_reg <= 1'b0;
                            op_reg <= '0;
                            acc_reg <= '0;
                            dacc_reg <= '0;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: state_reg <= S_WAIT;
                S_WAIT: if (mdone) begin
                    op_reg <= op_reg + 1'b1;
                    if (op_reg == 4'd6) state_reg <= S_EVAL;
                    else if (op_reg == 4'd10) state_reg <= S_CHK;
                    else state_reg <= S_MUL;
                    case (op_reg)
                        4'd0: t2_reg <= mprod;
                        4'd1: m2_reg <= mprod;
                        4'd2: tmp_reg <= mprod;
                        4'd3: acc_reg <= acc_reg + 3 * mprod;
                        4'd4: tmp_reg <= mprod;
                        4'd5: acc_reg <= acc_reg + 3 * mprod;
                        4'd6: acc_reg <= acc_reg + mprod;
                        4'd7: dacc_reg <= dacc_reg + 3 * mprod;
                        4'd8: tmp_reg <= mprod;
                        4'd9: dacc_reg <= dacc_reg + 6 * mprod;
                        4'd10: dacc_reg <= dacc_reg + 3 * mprod;
                        default: ;
                    endcase
                end
                S_EVAL: begin
                    if (yphase_reg) begin
                        state_reg <= S_FIN;
                    end else begin
                        err_reg <= acc_reg - tgt_reg;
                        if ((acc_reg - tgt_reg) <= Tol && (acc_reg - tgt_reg) >= -Tol
                                || iter_reg == IterW'(MaxIterations)) begin
                            yphase_reg <= 1'b1;
                            op_reg <= '0;
                            acc_reg <= '0;
                            state_reg <= S_MUL;
                        end else begin
                            if ((acc_reg - tgt_reg) > 0) up_reg <= t_reg;
                            else lo_reg <= t_reg;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_CHK: state_reg <= (dacc_reg > 0) ? S_DIV : S_STEP;
                S_DIV: state_reg <= S_DWAIT;
                S_DWAIT: if (ddone) state_reg <= S_STEP;
                S_STEP: begin
                    if (dacc_reg > 0 && cand > lo_reg && cand < up_reg) begin
                        t_reg <= cand;
                        mt_reg <= QOne - cand;
                    end else begin
                        t_reg <= mid;
                        mt_reg <= QOne - mid;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    op_reg <= '0;
                    acc_reg <= '0;
                    dacc_reg <= '0;
                    state_reg <= S_MUL;
                end
                S_FIN: begin
                    if (acc_reg <= 0) eased_reg <= '0;
                    else if (yr > VW'(1 << FracBits)) eased_reg <= 17'(1 << FracBits);
                    else eased_reg <= yr[16:0];
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end else begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_eased = eased_reg;

    `ASSERT_NEVER(a_no_overlap, aclk, aresetn, s_ready && m_valid)
    `ASSERT_NEVER(a_range, aclk, aresetn, m_valid && m_eased > 17'(1 << FracBits))
    `ASSERT_IMPL(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid)
endmodule

/* test/cubic_bezier_easing_checker.sv */
// Checker that predicts eased values and compares them with the block's results.
`timescale 1ns / 100ps
module cubic_bezier_easing_checker
    import cbe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [16:0] s_progress,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [16:0] m_eased,
    output int          fail_count,
    output int          pending
);
    localparam logic [1:0] ModeEntrance = 2'd2;
    localparam longint Unit = 64'sd1 << QBits;
    localparam longint ErrLimit = 64'sd1 << 10;
    localparam logic [16:0] FullScale = 17'(1 << FracBits);

    logic [16:0] eased_q[$];

    function automatic longint fx_mul(input longint x, input longint y);
        logic neg;
        logic [63:0] ux;
        logic [63:0] uy;
        logic [63:0] p;
        neg = (x < 0) ^ (y < 0);
        ux = (x < 0) ? -x : x;
        uy = (y < 0) ? -y : y;
        p = (ux * uy + (64'd1 << (QBits - 1))) >> QBits;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint curve_at(input longint a, input longint b, input longint t);
        longint mt;
        longint t2;
        longint m2;
        mt = Unit - t;
        t2 = fx_mul(t, t);
        m2 = fx_mul(mt, mt);
        return 3 * fx_mul(fx_mul(m2, t), a) + 3 * fx_mul(fx_mul(mt, t2), b) + fx_mul(t2, t);
    endfunction

    function automatic longint curve_slope(input longint a, input longint b, input longint t);
        longint mt;
        longint t2;
        longint m2;
        mt = Unit - t;
        t2 = fx_mul(t, t);
        m2 = fx_mul(mt, mt);
        return 3 * fx_mul(m2, a) + 6 * fx_mul(fx_mul(mt, t), b - a)
            + 3 * fx_mul(t2, Unit - b);
    endfunction

    function automatic logic [16:0] ease(input logic [1:0] mode, input logic [16:0] prog);
        longint x1;
        longint x2;
        longint y1;
        longint y2;
        longint target;
        longint t;
        longint lo;
        longint hi;
        longint err;
        longint d;
        longint cand;
        longint y;
        longint r;
        logic ok;
        y1 = 0;
        y2 = Unit;
        case (mode)
            ModeLinear: begin
                x1 = 0;
                x2 = Unit;
            end
            ModeExit: begin
                x1 = Unit;
                x2 = Unit;
            end
            default: begin
                x1 = 0;
                x2 = 0;
            end
        endcase
        if (prog == 0) return '0;
        if (prog >= FullScale) return FullScale;
        target = longint'(prog) << (QBits - FracBits);
        t = target;
        lo = 0;
        hi = Unit;
        for (int i = 0; i < MaxIterations; i++) begin
            err = curve_at(x1, x2, t) - target;
            if (err <= ErrLimit && err >= -ErrLimit) break;
            if (err > 0) hi = t;
            else lo = t;
            d = curve_slope(x1, x2, t);
            ok = 1'b0;
            if (d > 0) begin
                cand = t - (err * Unit) / d;
                if (cand > lo && cand < hi) begin
                    t = cand;
                    ok = 1'b1;
                end
            end
            if (!ok) t = (lo + hi) / 2;
        end
        y = curve_at(y1, y2, t);
        if (y <= 0) return '0;
        r = (y + (64'sd1 << (QBits - FracBits - 1))) >>> (QBits - FracBits);
        if (r > FullScale) r = FullScale;
        return 17'(r);
    endfunction

    assign pending = eased_q.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) eased_q.push_back(ease(s_mode, s_progress));
            if (m_valid && m_ready) begin
                if (eased_q.size() == 0) begin
                    $error("eased: result %0d with no item outstanding", m_eased);
                    fail_count <= fail_count + 1;
                end else if (eased_q[0] !== m_eased) begin
                    $error("eased: expected %0d, actual %0d", eased_q[0], m_eased);
                    fail_count <= fail_count + 1;
                    void'(eased_q.pop_front());
                end else begin
                    void'(eased_q.pop_front());
                end
            end
        end
    end
endmodule

/* test/cubic_bezier_easing_tb.sv */
// Testbench top: drives items into the easing block and gives the verdict.
`timescale 1ns / 100ps
module cubic_bezier_easing_tb;
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [16:0] s_progress;
    logic        m_valid;
    logic        m_ready;
    logic [16:0] m_eased;
    int          fail_count;
    int          pending;

    cubic_bezier_easing u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_progress(s_progress),
        .m_valid(m_valid), .m_ready(m_ready), .m_eased(m_eased)
    );

    cubic_bezier_easing_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_progress(s_progress),
        .m_valid(m_valid), .m_ready(m_ready), .m_eased(m_eased),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [16:0] prog, input int gap);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_mode = mode;
        s_progress = prog;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic [16:0] rand_progress();
        case ($urandom_range(0, 15))
            0: return 17'd0;
            1: return 17'($urandom_range(65536, 131071));
            2: return 17'($urandom_range(1, 16));
            3: return 17'($urandom_range(65520, 65535));
            default: return 17'($urandom_range(1, 65535));
        endcase
    endfunction

    initial begin
        int gap_mode;
        logic [16:0] corners[7];
        corners = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536, 17'd131071, 17'h0AAAA};
        s_valid = 1'b0;
        s_mode = '0;
        s_progress = '0;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        for (int m = 0; m < 4; m++) begin
            foreach (corners[k]) begin
                if (m < 3 || k < 3) send_item(2'(m), corners[k], 0);
            end
        end
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        for (int n = 0; n < 1000; n++) begin
            gap_mode = (n < 300) ? 0 : idle_len();
            send_item(2'($urandom_range(0, 3)), rand_progress(), gap_mode);
            if (n == 500) begin
                s_valid = 1'b0;
                while (pending != 0) @(negedge aclk);
            end
        end
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS cubic_bezier_easing");
        end else begin
            $display("FAIL cubic_bezier_easing");
        end
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        repeat (200) @(negedge aclk);
        m_ready = 1'b0;
        for (int c = 0; c < 5000; c++) @(negedge aclk);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 39) == 0) begin
                m_ready = 1'b0;
                repeat (idle_len()) @(negedge aclk);
            end else begin
                m_ready = ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        #200ms;
        $display("FAIL cubic_bezier_easing");
        $finish;
    end
endmodule

/* cubic_bezier_easing.f */
+incdir+hw/rtl
hw/rtl/cbe_pkg.sv
hw/rtl/cbe_mul.sv
hw/rtl/cbe_div.sv
hw/rtl/cubic_bezier_easing.sv
test/cubic_bezier_easing_checker.sv
test/cubic_bezier_easing_tb.sv
